// ----- rtl/psalu_pkg.sv -----
// Shared opcodes and stream field positions for the packed-integer SIMD ALU.
// No dependencies; imported by the ALU and its port checker.
package psalu_pkg;

   typedef logic [5:0] opcode_type;

   localparam opcode_type OP_PAND      = 6'd0;
   localparam opcode_type OP_PANDN     = 6'd1;
   localparam opcode_type OP_POR       = 6'd2;
   localparam opcode_type OP_PXOR      = 6'd3;
   localparam opcode_type OP_PADDB     = 6'd4;
   localparam opcode_type OP_PSUBB     = 6'd5;
   localparam opcode_type OP_PADDSB    = 6'd6;
   localparam opcode_type OP_PSUBSB    = 6'd7;
   localparam opcode_type OP_PADDUSB   = 6'd8;
   localparam opcode_type OP_PSUBUSB   = 6'd9;
   localparam opcode_type OP_PCMPEQB   = 6'd10;
   localparam opcode_type OP_PCMPGTB   = 6'd11;
   localparam opcode_type OP_PAVGB     = 6'd12;
   localparam opcode_type OP_PMINUB    = 6'd13;
   localparam opcode_type OP_PMAXUB    = 6'd14;
   localparam opcode_type OP_PADDW     = 6'd15;
   localparam opcode_type OP_PSUBW     = 6'd16;
   localparam opcode_type OP_PADDSW    = 6'd17;
   localparam opcode_type OP_PSUBSW    = 6'd18;
   localparam opcode_type OP_PADDUSW   = 6'd19;
   localparam opcode_type OP_PSUBUSW   = 6'd20;
   localparam opcode_type OP_PCMPEQW   = 6'd21;
   localparam opcode_type OP_PCMPGTW   = 6'd22;
   localparam opcode_type OP_PAVGW     = 6'd23;
   localparam opcode_type OP_PMINSW    = 6'd24;
   localparam opcode_type OP_PMAXSW    = 6'd25;
   localparam opcode_type OP_PMULLW    = 6'd26;
   localparam opcode_type OP_PMULHW    = 6'd27;
   localparam opcode_type OP_PMULHUW   = 6'd28;
   localparam opcode_type OP_PADDD     = 6'd29;
   localparam opcode_type OP_PSUBD     = 6'd30;
   localparam opcode_type OP_PCMPEQD   = 6'd31;
   localparam opcode_type OP_PCMPGTD   = 6'd32;
   localparam opcode_type OP_PADDQ     = 6'd33;
   localparam opcode_type OP_PSUBQ     = 6'd34;
   localparam opcode_type OP_PUNPCKLBW = 6'd35;
   localparam opcode_type OP_PUNPCKLWD = 6'd36;
   localparam opcode_type OP_PUNPCKLDQ = 6'd37;
   localparam opcode_type OP_PUNPCKHBW = 6'd38;
   localparam opcode_type OP_PUNPCKHWD = 6'd39;
   localparam opcode_type OP_PUNPCKHDQ = 6'd40;
   localparam opcode_type OP_PACKUSWB  = 6'd41;
   localparam opcode_type OP_PACKSSWB  = 6'd42;
   localparam opcode_type OP_PACKSSDW  = 6'd43;
   localparam opcode_type OP_PSLLW     = 6'd44;
   localparam opcode_type OP_PSRLW     = 6'd45;
   localparam opcode_type OP_PSRAW     = 6'd46;
   localparam opcode_type OP_PSLLD     = 6'd47;
   localparam opcode_type OP_PSRLD     = 6'd48;
   localparam opcode_type OP_PSRAD     = 6'd49;
   localparam opcode_type OP_PSLLQ     = 6'd50;
   localparam opcode_type OP_PSRLQ     = 6'd51;
   localparam opcode_type OP_PMADDWD   = 6'd52;
   localparam opcode_type OP_PSADBW    = 6'd53;
   localparam opcode_type OP_PSHUFW    = 6'd54;
   localparam opcode_type OP_PSHUFD    = 6'd55;

   localparam int REQ_DATA_W = 264;
   localparam int REQ_USER_W = 7;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 2;

   localparam int RSP_USER_WIDE_BIT = 0;
   localparam int RSP_USER_OK_BIT   = 1;

endpackage

// ----- rtl/packed_integer_simd_alu.sv -----
// Packed-integer SIMD ALU (MMX/SSE2 integer subset), top level.
// Depends on psalu_pkg for opcodes and stream widths.

// Two register stages: the request register feeds all lane logic, whose
// result lands in the response register. A request is taken every cycle
// while the response side keeps up; an accepted request passes through the
// request register and then the response register. Each 16-bit lane owns a
// 17x17 multiplier shared by the multiply and multiply-add operations;
// stalls on the response side back up through both registers.
module packed_integer_simd_alu (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // a_lo, a_hi, b_lo, b_hi, imm
   input  logic [psalu_pkg::REQ_DATA_W-1:0]       req_tdata,
   // command, wide
   input  logic [psalu_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // result_lo, result_hi
   output logic [psalu_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // result_wide, ok
   output logic [psalu_pkg::RSP_USER_W-1:0]       rsp_tuser
);
   import psalu_pkg::*;

   logic         v1_ff, v1_in, v2_ff, v2_in;
   logic         adv1, adv2;
   opcode_type   cmd_ff;
   logic [127:0] a_ff, b_ff;
   logic         wide_ff;
   logic [7:0]   imm_ff;
   logic [127:0] data_ff, data_in;
   logic [1:0]   user_ff, user_in;

   logic [127:0] logic_r, byte_r, word_r, dword_r, qword_r, misc_r, all_r;
   logic [31:0]  prod_w [8];
   logic         ok, rwide;

   function automatic logic [7:0] sat_sb(input logic [15:0] v);
      if ($signed(v) > 16'sd127) return 8'h7f;
      else if ($signed(v) < -16'sd128) return 8'h80;
      else return v[7:0];
   endfunction

   function automatic logic [7:0] sat_ub(input logic [15:0] v);
      if (v[15]) return 8'h00;
      else if (v[14:8] != 7'd0) return 8'hff;
      else return v[7:0];
   endfunction

   function automatic logic [15:0] sat_sw(input logic [31:0] v);
      if ($signed(v) > 32'sd32767) return 16'h7fff;
      else if ($signed(v) < -32'sd32768) return 16'h8000;
      else return v[15:0];
   endfunction

   // handshake: the second stage frees when empty or drained
   assign adv2       = !v2_ff || rsp_tready;
   assign adv1       = adv2;
   assign req_tready = !v1_ff || adv1;
   assign v1_in      = req_tready ? req_tvalid : v1_ff;
   assign v2_in      = adv2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff  <= req_tuser[5:0];
         wide_ff <= req_tuser[6];
         a_ff    <= {req_tuser[6] ? req_tdata[127:64] : 64'd0, req_tdata[63:0]};
         b_ff    <= req_tdata[255:128];
         imm_ff  <= req_tdata[263:256];
      end
      if (adv2 && v1_ff) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   // bitwise
   always_comb begin
      unique case (cmd_ff)
         OP_PAND:  logic_r = a_ff & b_ff;
         OP_PANDN: logic_r = ~a_ff & b_ff;
         OP_POR:   logic_r = a_ff | b_ff;
         OP_PXOR:  logic_r = a_ff ^ b_ff;
         default:  logic_r = '0;
      endcase
   end

   // byte lanes
   always_comb begin
      logic [7:0] xb, yb, rb;
      logic [8:0] su, du, ss, ds;
      logic [9:0] av;
      for (int i = 0; i < 16; i++) begin
         xb = a_ff[8*i +: 8];
         yb = b_ff[8*i +: 8];
         su = {1'b0, xb} + {1'b0, yb};
         du = {1'b0, xb} - {1'b0, yb};
         ss = {xb[7], xb} + {yb[7], yb};
         ds = {xb[7], xb} - {yb[7], yb};
         av = {2'b0, xb} + {2'b0, yb} + 10'd1;
         unique case (cmd_ff)
            OP_PADDB:   rb = su[7:0];
            OP_PSUBB:   rb = du[7:0];
            OP_PADDSB:  rb = (ss[8] != ss[7]) ? (ss[8] ? 8'h80 : 8'h7f) : ss[7:0];
            OP_PSUBSB:  rb = (ds[8] != ds[7]) ? (ds[8] ? 8'h80 : 8'h7f) : ds[7:0];
            OP_PADDUSB: rb = su[8] ? 8'hff : su[7:0];
            OP_PSUBUSB: rb = du[8] ? 8'h00 : du[7:0];
            OP_PCMPEQB: rb = (xb == yb) ? 8'hff : 8'h00;
            OP_PCMPGTB: rb = ($signed(xb) > $signed(yb)) ? 8'hff : 8'h00;
            OP_PAVGB:   rb = av[8:1];
            OP_PMINUB:  rb = (xb < yb) ? xb : yb;
            OP_PMAXUB:  rb = (xb > yb) ? xb : yb;
            default:    rb = '0;
         endcase
         byte_r[8*i +: 8] = rb;
      end
   end

   // word lanes, including the lane multipliers and word shifts
   always_comb begin
      logic [15:0]        xw, yw, rw;
      logic [16:0]        su, du, ss, ds, av;
      logic [16:0]        mx, my;
      logic signed [33:0] p;
      logic               ext, big;
      big = |b_ff[63:4];
      ext = cmd_ff != OP_PMULHUW;
      for (int i = 0; i < 8; i++) begin
         xw = a_ff[16*i +: 16];
         yw = b_ff[16*i +: 16];
         su = {1'b0, xw} + {1'b0, yw};
         du = {1'b0, xw} - {1'b0, yw};
         ss = {xw[15], xw} + {yw[15], yw};
         ds = {xw[15], xw} - {yw[15], yw};
         av = {1'b0, xw} + {1'b0, yw} + 17'd1;
         mx = {ext & xw[15], xw};
         my = {ext & yw[15], yw};
         p  = $signed(mx) * $signed(my);
         prod_w[i] = p[31:0];
         unique case (cmd_ff)
            OP_PADDW:   rw = su[15:0];
            OP_PSUBW:   rw = du[15:0];
            OP_PADDSW:  rw = (ss[16] != ss[15]) ? (ss[16] ? 16'h8000 : 16'h7fff) : ss[15:0];
            OP_PSUBSW:  rw = (ds[16] != ds[15]) ? (ds[16] ? 16'h8000 : 16'h7fff) : ds[15:0];
            OP_PADDUSW: rw = su[16] ? 16'hffff : su[15:0];
            OP_PSUBUSW: rw = du[16] ? 16'h0000 : du[15:0];
            OP_PCMPEQW: rw = (xw == yw) ? 16'hffff : 16'h0000;
            OP_PCMPGTW: rw = ($signed(xw) > $signed(yw)) ? 16'hffff : 16'h0000;
            OP_PAVGW:   rw = av[16:1];
            OP_PMINSW:  rw = ($signed(xw) < $signed(yw)) ? xw : yw;
            OP_PMAXSW:  rw = ($signed(xw) > $signed(yw)) ? xw : yw;
            OP_PMULLW:  rw = p[15:0];
            OP_PMULHW:  rw = p[31:16];
            OP_PMULHUW: rw = p[31:16];
            OP_PSLLW:   rw = big ? 16'h0 : xw << b_ff[3:0];
            OP_PSRLW:   rw = big ? 16'h0 : xw >> b_ff[3:0];
            OP_PSRAW:   rw = big ? {16{xw[15]}} : 16'($signed(xw) >>> b_ff[3:0]);
            default:    rw = '0;
         endcase
         word_r[16*i +: 16] = rw;
      end
   end

   // dword lanes and multiply-add
   always_comb begin
      logic [31:0] xd, yd, rd;
      logic        big;
      big = |b_ff[63:5];
      for (int i = 0; i < 4; i++) begin
         xd = a_ff[32*i +: 32];
         yd = b_ff[32*i +: 32];
         unique case (cmd_ff)
            OP_PADDD:   rd = xd + yd;
            OP_PSUBD:   rd = xd - yd;
            OP_PCMPEQD: rd = (xd == yd) ? 32'hffffffff : 32'h0;
            OP_PCMPGTD: rd = ($signed(xd) > $signed(yd)) ? 32'hffffffff : 32'h0;
            OP_PSLLD:   rd = big ? 32'h0 : xd << b_ff[4:0];
            OP_PSRLD:   rd = big ? 32'h0 : xd >> b_ff[4:0];
            OP_PSRAD:   rd = big ? {32{xd[31]}} : 32'($signed(xd) >>> b_ff[4:0]);
            OP_PMADDWD: rd = prod_w[2*i] + prod_w[2*i+1];
            default:    rd = '0;
         endcase
         dword_r[32*i +: 32] = rd;
      end
   end

   // qword lanes
   always_comb begin
      logic [63:0] xq, yq, rq;
      logic        big;
      big = |b_ff[63:6];
      for (int i = 0; i < 2; i++) begin
         xq = a_ff[64*i +: 64];
         yq = b_ff[64*i +: 64];
         unique case (cmd_ff)
            OP_PADDQ: rq = xq + yq;
            OP_PSUBQ: rq = xq - yq;
            OP_PSLLQ: rq = big ? 64'h0 : xq << b_ff[5:0];
            OP_PSRLQ: rq = big ? 64'h0 : xq >> b_ff[5:0];
            default:  rq = '0;
         endcase
         qword_r[64*i +: 64] = rq;
      end
   end

   // unpacks, packs, sum of absolute differences, shuffles
   always_comb begin
      logic [3:0]  bidx;
      logic [2:0]  widx;
      logic [1:0]  didx;
      logic [1:0]  sel;
      logic        hi;
      logic [63:0] pav, pbv;
      logic [7:0]  xb, yb;
      logic [10:0] sad;
      hi     = cmd_ff == OP_PUNPCKHBW || cmd_ff == OP_PUNPCKHWD || cmd_ff == OP_PUNPCKHDQ;
      misc_r = '0;
      pav    = '0;
      pbv    = '0;
      bidx   = '0;
      widx   = '0;
      didx   = '0;
      sel    = '0;
      xb     = '0;
      yb     = '0;
      sad    = '0;
      unique case (cmd_ff)
         OP_PUNPCKLBW, OP_PUNPCKHBW: begin
            for (int i = 0; i < 8; i++) begin
               bidx = (hi ? (wide_ff ? 4'd8 : 4'd4) : 4'd0) + 4'(i);
               misc_r[16*i +: 8]     = a_ff[{bidx, 3'b0} +: 8];
               misc_r[16*i + 8 +: 8] = b_ff[{bidx, 3'b0} +: 8];
            end
         end
         OP_PUNPCKLWD, OP_PUNPCKHWD: begin
            for (int i = 0; i < 4; i++) begin
               widx = (hi ? (wide_ff ? 3'd4 : 3'd2) : 3'd0) + 3'(i);
               misc_r[32*i +: 16]      = a_ff[{widx, 4'b0} +: 16];
               misc_r[32*i + 16 +: 16] = b_ff[{widx, 4'b0} +: 16];
            end
         end
         OP_PUNPCKLDQ, OP_PUNPCKHDQ: begin
            for (int i = 0; i < 2; i++) begin
               didx = (hi ? (wide_ff ? 2'd2 : 2'd1) : 2'd0) + 2'(i);
               misc_r[64*i +: 32]      = a_ff[{didx, 5'b0} +: 32];
               misc_r[64*i + 32 +: 32] = b_ff[{didx, 5'b0} +: 32];
            end
         end
         OP_PACKUSWB, OP_PACKSSWB: begin
            for (int i = 0; i < 8; i++) begin
               pav[8*i +: 8] = (cmd_ff == OP_PACKUSWB) ? sat_ub(a_ff[16*i +: 16])
                                                       : sat_sb(a_ff[16*i +: 16]);
               pbv[8*i +: 8] = (cmd_ff == OP_PACKUSWB) ? sat_ub(b_ff[16*i +: 16])
                                                       : sat_sb(b_ff[16*i +: 16]);
            end
            misc_r = wide_ff ? {pbv, pav} : {64'd0, pbv[31:0], pav[31:0]};
         end
         OP_PACKSSDW: begin
            for (int i = 0; i < 4; i++) begin
               pav[16*i +: 16] = sat_sw(a_ff[32*i +: 32]);
               pbv[16*i +: 16] = sat_sw(b_ff[32*i +: 32]);
            end
            misc_r = wide_ff ? {pbv, pav} : {64'd0, pbv[31:0], pav[31:0]};
         end
         OP_PSADBW: begin
            for (int l = 0; l < 2; l++) begin
               sad = '0;
               for (int k = 0; k < 8; k++) begin
                  xb  = a_ff[64*l + 8*k +: 8];
                  yb  = b_ff[64*l + 8*k +: 8];
                  sad = sad + {3'd0, (xb > yb) ? xb - yb : yb - xb};
               end
               misc_r[64*l +: 64] = {53'd0, sad};
            end
         end
         OP_PSHUFW: begin
            for (int i = 0; i < 4; i++) begin
               sel = imm_ff[2*i +: 2];
               misc_r[16*i +: 16] = b_ff[{sel, 4'b0} +: 16];
            end
         end
         OP_PSHUFD: begin
            for (int i = 0; i < 4; i++) begin
               sel = imm_ff[2*i +: 2];
               misc_r[32*i +: 32] = b_ff[{sel, 5'b0} +: 32];
            end
         end
         default: misc_r = '0;
      endcase
   end

   assign all_r = logic_r | byte_r | word_r | dword_r | qword_r | misc_r;
   assign ok    = cmd_ff <= OP_PSHUFD;

   always_comb begin
      priority if (cmd_ff == OP_PSHUFW) rwide = 1'b0;
      else if (cmd_ff == OP_PSHUFD)     rwide = 1'b1;
      else                              rwide = ok & wide_ff;
   end

   assign data_in = {rwide ? all_r[127:64] : 64'd0, all_r[63:0]};
   always_comb begin
      user_in                    = '0;
      user_in[RSP_USER_WIDE_BIT] = rwide;
      user_in[RSP_USER_OK_BIT]   = ok;
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ----- rtl/psalu_chk.sv -----
// Port-level checker for the packed-integer SIMD ALU, bound to the top level.
// Depends on psalu_pkg for stream widths and response flag positions.
module psalu_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [psalu_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [psalu_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import psalu_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_bad_op_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_OK_BIT] |->
         rsp_tdata == '0 && !rsp_tuser[RSP_USER_WIDE_BIT])
      else $error("unsupported opcode gave data");

   a_narrow_hi_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_WIDE_BIT] |-> rsp_tdata[127:64] == 64'd0)
      else $error("narrow response has high half set");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

endmodule

bind packed_integer_simd_alu psalu_chk u_psalu_chk (.*);
